[sv/rpb_pkg.sv]
// Shared types and constants of the RGB palette builder.
package rpb_pkg;

    // Field widths fixed by the pixel and result formats.
    localparam int CompW  = 8;
    localparam int ColorW = 24;
    localparam int IdxW   = 8;
    localparam int CountW = 9;
    localparam int CfgIdxW = 1;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_TR_ENABLE = 1'b0,
        REG_TR_COLOR  = 1'b1
    } rpb_reg_t;

    // Search token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic              done;
        logic              fresh;
        logic [IdxW-1:0]   idx;
        logic [ColorW-1:0] color;
    } rpb_tok_t;

    // One finished result.
    typedef struct packed {
        logic [IdxW-1:0]   color_index;
        logic              is_new;
        logic              overflow;
        logic [CountW-1:0] color_count;
    } rpb_res_t;

endpackage

[sv/rpb_if.sv]
// Channel interfaces of the RGB palette builder: pixels, results and configuration.
interface rpb_pix_if
    import rpb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CompW-1:0]  red;
    logic [CompW-1:0]  green;
    logic [CompW-1:0]  blue;
    logic              first_pixel;

    modport source (output valid, red, green, blue, first_pixel, input ready);
    modport sink   (input valid, red, green, blue, first_pixel, output ready);
endinterface

interface rpb_res_if
    import rpb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [IdxW-1:0]   color_index;
    logic              is_new;
    logic              overflow;
    logic [CountW-1:0] color_count;

    modport source (output valid, color_index, is_new, overflow, color_count, input ready);
    modport sink   (input valid, color_index, is_new, overflow, color_count, output ready);
endinterface

interface rpb_cfg_if
    import rpb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [ColorW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/rpb_cell.sv]
// One palette cell: holds one entry and compares or appends as the token passes.
module rpb_cell
    import rpb_pkg::*;
#(
    parameter int CELL_IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rpb_tok_t          tok_in,
    input  logic [CountW-1:0] count,
    input  logic              load_en,
    input  logic [ColorW-1:0] load_color,
    output rpb_tok_t          tok_out
);

    localparam logic [CountW-1:0] CellPos = CountW'(CELL_IDX);

    logic [ColorW-1:0] entry_reg;
    rpb_tok_t          tok_reg;
    rpb_tok_t          tok_next;
    logic              searching;
    logic              hit;
    logic              append;

    // An entry takes part in the compare only when it is below the fill count.
    assign searching = tok_in.valid && !tok_in.done;
    assign hit       = searching && (CellPos < count) && (entry_reg == tok_in.color);
    assign append    = searching && (CellPos == count);

    // Resolve the token here on a hit or on the first free entry.
    always_comb
    begin
        tok_next = tok_in;
        if (hit || append)
        begin
            tok_next.done  = 1'b1;
            tok_next.fresh = append;
            tok_next.idx   = CellPos[IdxW-1:0];
        end
    end

    // Entry storage: written by an append or by the key preload.
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            entry_reg <= load_color;
        end
        else if (append)
        begin
            entry_reg <= tok_in.color;
        end
    end

    // Hand the token to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[sv/rpb_ctrl.sv]
// Controller: handshakes, configuration, fill count, overflow and result staging.
module rpb_ctrl
    import rpb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rpb_pix_if.sink           pix,
    rpb_res_if.source         res,
    rpb_cfg_if.sink           cfg,
    input  rpb_tok_t          tok_exit,
    output rpb_tok_t          tok_launch,
    output logic [CountW-1:0] count,
    output logic              key_load,
    output logic [ColorW-1:0] key_color
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_HOLD   = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic              tr_en_reg;
    logic [ColorW-1:0] tr_color_reg;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;
    logic              ovf_reg;
    logic              ovf_next;
    rpb_tok_t          launch_reg;
    rpb_tok_t          launch_next;
    rpb_res_t          pend_reg;
    rpb_res_t          pend_next;
    rpb_res_t          out_reg;
    logic              out_valid_reg;
    logic              accept;
    logic              out_free;
    logic [CountW-1:0] start_count;
    logic              start_ovf;

    assign pix.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = pix.valid && pix.ready;
    assign out_free  = !out_valid_reg || res.ready;

    // Palette state as the pixel sees it, after an optional clear.
    assign start_count = pix.first_pixel ? CountW'(tr_en_reg) : count_reg;
    assign start_ovf   = pix.first_pixel ? 1'b0 : ovf_reg;

    assign key_load  = accept && pix.first_pixel && tr_en_reg;
    assign key_color = tr_color_reg;

    // Sequencing of one pixel: launch and wait for the chain, or skip the search under overflow; stage the result.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        pend_next   = pend_reg;
        launch_next = launch_reg;
        launch_next.valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    count_next = start_count;
                    ovf_next   = start_ovf;
                    if (start_ovf)
                    begin
                        pend_next.color_index = '0;
                        pend_next.is_new      = 1'b0;
                        pend_next.overflow    = 1'b1;
                        pend_next.color_count = start_count;
                        state_next            = S_HOLD;
                    end
                    else
                    begin
                        launch_next.valid = 1'b1;
                        launch_next.done  = 1'b0;
                        launch_next.fresh = 1'b0;
                        launch_next.idx   = '0;
                        launch_next.color = {pix.red, pix.green, pix.blue};
                        state_next        = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (tok_exit.valid)
                begin
                    if (tok_exit.done)
                    begin
                        count_next = count_reg + CountW'(tok_exit.fresh);
                        pend_next.color_index = tok_exit.idx;
                        pend_next.is_new      = tok_exit.fresh;
                        pend_next.overflow    = 1'b0;
                        pend_next.color_count = count_reg + CountW'(tok_exit.fresh);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        pend_next.color_index = '0;
                        pend_next.is_new      = 1'b0;
                        pend_next.overflow    = 1'b1;
                        pend_next.color_count = count_reg;
                    end
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            launch_reg       <= '0;
            out_valid_reg    <= 1'b0;
            tr_en_reg        <= 1'b0;
            tr_color_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ovf_reg          <= ovf_next;
            launch_reg       <= launch_next;
            if (state_reg == S_HOLD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                unique case (rpb_reg_t'(cfg.index))
                    REG_TR_ENABLE: tr_en_reg    <= cfg.data[0];
                    REG_TR_COLOR:  tr_color_reg <= cfg.data;
                    default:       tr_en_reg    <= tr_en_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_reg         <= pend_next;
        if (state_reg == S_HOLD && out_free)
        begin
            out_reg <= pend_reg;
        end
    end

    assign tok_launch      = launch_reg;
    assign count           = count_reg;
    assign res.valid       = out_valid_reg;
    assign res.color_index = out_reg.color_index;
    assign res.is_new      = out_reg.is_new;
    assign res.overflow    = out_reg.overflow;
    assign res.color_count = out_reg.color_count;

endmodule

[sv/rgb_palette_builder.sv]
// Top level of the RGB palette builder: controller plus the chain of palette cells.
//
// Each accepted pixel is looked up in a palette of up to MAX_COLORS distinct colors
// and answered with its index; a color not yet present is appended (is_new), a color
// past the limit sets a sticky overflow until the next first_pixel, which clears the
// palette and, when enabled, preloads the transparent key as entry zero. The palette
// lives in a row of MAX_COLORS cells; a search token enters the first cell and moves
// one cell per cycle, and the result is staged once the token leaves the last cell;
// the next pixel is taken only after that, and a pixel arriving while overflow is set
// skips the search. The finished result waits in an output register, so the next
// pixel is taken while it is still pending; a result that is finished while the
// previous one is still unread holds the controller until the output register frees.
// Configuration writes are taken in any cycle.
module rgb_palette_builder
    import rpb_pkg::*;
#(
    parameter int MAX_COLORS = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    rpb_pix_if.sink   pix,
    rpb_res_if.source res,
    rpb_cfg_if.sink   cfg
);

    rpb_tok_t          chain [MAX_COLORS+1];
    logic [CountW-1:0] count;
    logic              key_load;
    logic [ColorW-1:0] key_color;

    // Sequencing and result staging.
    rpb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .res        (res),
        .cfg        (cfg),
        .tok_exit   (chain[MAX_COLORS]),
        .tok_launch (chain[0]),
        .count      (count),
        .key_load   (key_load),
        .key_color  (key_color)
    );

    // Row of palette cells; only the first one takes the key preload.
    for (genvar k = 0; k < MAX_COLORS; k++)
    begin : g_cell
        rpb_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .tok_in     (chain[k]),
            .count      (count),
            .load_en    ((k == 0) ? key_load : 1'b0),
            .load_color (key_color),
            .tok_out    (chain[k+1])
        );
    end

endmodule

[sv/rpb_checker.sv]
// Port-level checks of the RGB palette builder and their binding to the top level.
module rpb_checker
    import rpb_pkg::*;
#(
    parameter int MAX_COLORS = 256
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [IdxW-1:0]   color_index,
    input logic              is_new,
    input logic              overflow,
    input logic [CountW-1:0] color_count
);

    // A result waiting for the sink keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({color_index, is_new, overflow, color_count}))
        else $error("result payload changed while stalled");

    // A newly appended color is the last entry of the palette.
    a_new_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_new |-> !overflow && (CountW'(color_index) + 1'b1 == color_count))
        else $error("new entry index does not match color count");

    // Overflowed pixels report index zero and nothing new.
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> color_index == '0 && !is_new)
        else $error("overflow result carries an index or a new flag");

    // The fill count never passes the palette size.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> color_count <= CountW'(MAX_COLORS))
        else $error("color count exceeds palette size");

endmodule

bind rgb_palette_builder rpb_checker #(
    .MAX_COLORS (MAX_COLORS)
) u_rpb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .color_index (res.color_index),
    .is_new      (res.is_new),
    .overflow    (res.overflow),
    .color_count (res.color_count)
);

[tb/sv/tb_rgb_palette_builder.sv]
// Self-checking testbench of the RGB palette builder: directed table, then random images.
module tb_rgb_palette_builder;
    import rpb_pkg::*;

    localparam int MAX_COLORS     = 256;
    localparam int TOTAL_ITEMS    = 1350;
    localparam int WATCHDOG_LIMIT = 8 * (MAX_COLORS + 2) + 500;
    localparam int SETTLE_CYCLES  = MAX_COLORS + 4;

    // Kind of a row in the directed table.
    typedef enum logic {
        ROW_PIXEL = 1'b0,
        ROW_WRITE = 1'b1
    } row_kind_t;

    // One directed row: a pixel, or a register write between phases.
    typedef struct packed {
        row_kind_t         kind;
        rpb_reg_t          reg_idx;
        logic [ColorW-1:0] value;
        logic              first;
        logic              typed;
        rpb_res_t          want;
    } dir_row_t;

    localparam rpb_res_t NO_RES = '0;
    localparam int       DIR_ROWS = 24;

    // Results that can be read off directly are typed in; the rest come from the predictor.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_PIXEL, REG_TR_ENABLE, 24'h000000, 1'b0, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'hFFFFFF, 1'b0, 1'b1, '{8'd1, 1'b1, 1'b0, 9'd2}},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'h000000, 1'b0, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd2}},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'hFFFFFF, 1'b1, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'hFF0000, 1'b0, 1'b0, NO_RES},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'h00FF00, 1'b0, 1'b0, NO_RES},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'h0000FF, 1'b0, 1'b0, NO_RES},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'hFF0000, 1'b0, 1'b0, NO_RES},
        '{ROW_WRITE, REG_TR_COLOR,  24'hFFFFFF, 1'b0, 1'b0, NO_RES},
        '{ROW_WRITE, REG_TR_ENABLE, 24'h000001, 1'b0, 1'b0, NO_RES},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'h123456, 1'b0, 1'b0, NO_RES},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'hFFFFFF, 1'b1, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd1}},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'h000000, 1'b0, 1'b1, '{8'd1, 1'b1, 1'b0, 9'd2}},
        '{ROW_WRITE, REG_TR_COLOR,  24'h000000, 1'b0, 1'b0, NO_RES},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'h000000, 1'b1, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd1}},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'hAA55AA, 1'b1, 1'b0, NO_RES},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'h55AA55, 1'b0, 1'b0, NO_RES},
        '{ROW_WRITE, REG_TR_COLOR,  24'hA5C35A, 1'b0, 1'b0, NO_RES},
        '{ROW_WRITE, REG_TR_ENABLE, 24'hFFFFFE, 1'b0, 1'b0, NO_RES},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'h010203, 1'b1, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'h807F01, 1'b0, 1'b0, NO_RES},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'hA5C35A, 1'b0, 1'b0, NO_RES},
        '{ROW_WRITE, REG_TR_ENABLE, 24'h000001, 1'b0, 1'b0, NO_RES},
        '{ROW_PIXEL, REG_TR_ENABLE, 24'hA5C35A, 1'b1, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd1}}
    };

    logic clk;
    logic rst_n;

    rpb_pix_if pix_ch ();
    rpb_res_if res_ch ();
    rpb_cfg_if cfg_ch ();

    rgb_palette_builder #(
        .MAX_COLORS (MAX_COLORS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state: its own palette copy and register shadows.
    logic [ColorW-1:0] pal_colors [MAX_COLORS];
    int                pal_used;
    logic              pal_overflow;
    logic              key_enable;
    logic [ColorW-1:0] key_color;

    rpb_res_t pending_results [$];
    int       err_count;
    int       pixels_sent;
    int       images_started;
    int       new_entries;
    int       overflow_pixels;
    int       reg_writes;
    int       results_seen;
    bit       no_idle;

    // Palette lookup: clear on a first pixel, search, append or flag overflow.
    function automatic rpb_res_t lookup_pixel(input logic [ColorW-1:0] color,
                                              input logic first);
        rpb_res_t r;
        int       k;
        int       hit_at;
        hit_at = -1;
        if (first)
        begin
            pal_used     = 0;
            pal_overflow = 1'b0;
            if (key_enable)
            begin
                pal_colors[0] = key_color;
                pal_used      = 1;
            end
        end
        r.color_index = '0;
        r.is_new      = 1'b0;
        if (!pal_overflow)
        begin
            for (k = 0; k < pal_used && hit_at < 0; k++)
            begin
                if (pal_colors[k] == color)
                    hit_at = k;
            end
            if (hit_at >= 0)
            begin
                r.color_index = IdxW'(hit_at);
            end
            else if (pal_used < MAX_COLORS)
            begin
                pal_colors[pal_used] = color;
                r.color_index        = IdxW'(pal_used);
                r.is_new             = 1'b1;
                pal_used++;
            end
            else
            begin
                pal_overflow = 1'b1;
            end
        end
        r.overflow    = pal_overflow;
        r.color_count = CountW'(pal_used);
        return r;
    endfunction

    // Idle length: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 60);
    endfunction

    // Offer one pixel, wait for it to be taken, record what it should produce.
    task automatic put_pixel(input logic [ColorW-1:0] color, input logic first,
                             input bit typed, input rpb_res_t want);
        int       gap;
        rpb_res_t pred;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.red         <= color[23:16];
        pix_ch.green       <= color[15:8];
        pix_ch.blue        <= color[7:0];
        pix_ch.first_pixel <= first;
        do
            @(posedge clk);
        while (!pix_ch.ready);
        pred = lookup_pixel(color, first);
        pending_results.push_back(typed ? want : pred);
        pixels_sent++;
        if (first)
            images_started++;
        if (pred.is_new)
            new_entries++;
        if (pred.overflow)
            overflow_pixels++;
        @(negedge clk);
    endtask

    // Hold off the pixel side until every result is back.
    task automatic drain_results();
        pix_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // One register write on the configuration channel, taken while the block is idle.
    task automatic write_reg(input rpb_reg_t idx, input logic [ColorW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_TR_ENABLE)
            key_enable = data[0];
        else
            key_color = data;
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: ready with random stalls.
    initial
    begin
        int stall;
        stall        = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    stall = pick_gap();
            end
        end
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge clk)
    begin
        rpb_res_t exp_res;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: color_index %0d is_new %0b overflow %0b count %0d",
                       res_ch.color_index, res_ch.is_new, res_ch.overflow,
                       res_ch.color_count);
                err_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (res_ch.color_index !== exp_res.color_index)
                begin
                    $error("color_index: expected %0d, got %0d",
                           exp_res.color_index, res_ch.color_index);
                    err_count++;
                end
                if (res_ch.is_new !== exp_res.is_new)
                begin
                    $error("is_new: expected %0b, got %0b", exp_res.is_new, res_ch.is_new);
                    err_count++;
                end
                if (res_ch.overflow !== exp_res.overflow)
                begin
                    $error("overflow: expected %0b, got %0b",
                           exp_res.overflow, res_ch.overflow);
                    err_count++;
                end
                if (res_ch.color_count !== exp_res.color_count)
                begin
                    $error("color_count: expected %0d, got %0d",
                           exp_res.color_count, res_ch.color_count);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with no item taken on any channel.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus: reset, directed table, then random images.
    initial
    begin
        logic [ColorW-1:0] pool [8];
        logic [ColorW-1:0] color;
        logic [ColorW-1:0] base;
        logic [ColorW-1:0] stride;
        logic              first;
        int                pool_n;
        int                len;
        int                phase;
        int                kind;
        int                i;

        // Known values on every input from time zero.
        rst_n              = 1'b0;
        pix_ch.valid       = 1'b0;
        pix_ch.red         = '0;
        pix_ch.green       = '0;
        pix_ch.blue        = '0;
        pix_ch.first_pixel = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_TR_ENABLE;
        cfg_ch.data        = '0;
        err_count          = 0;
        pixels_sent        = 0;
        images_started     = 0;
        new_entries        = 0;
        overflow_pixels    = 0;
        reg_writes         = 0;
        results_seen       = 0;
        no_idle            = 1'b0;
        pal_used           = 0;
        pal_overflow       = 1'b0;
        key_enable         = 1'b0;
        key_color          = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table; writes wait until the block has gone idle.
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TABLE[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(DIR_TABLE[i].reg_idx, DIR_TABLE[i].value);
            end
            else
            begin
                put_pixel(DIR_TABLE[i].value, DIR_TABLE[i].first, DIR_TABLE[i].typed,
                          DIR_TABLE[i].want);
            end
        end

        // Random images, each phase starting from an idle block.
        phase = 0;
        while (pixels_sent < TOTAL_ITEMS)
        begin
            drain_results();
            no_idle = ($urandom_range(0, 4) == 0);

            // Occasional register changes, extremes included.
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_TR_ENABLE, {23'($urandom_range(0, 8388607)), 1'b0} |
                                         ColorW'($urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_TR_COLOR, 24'hFFFFFF);
                    1:       write_reg(REG_TR_COLOR, 24'h000000);
                    default: write_reg(REG_TR_COLOR, ColorW'($urandom));
                endcase
            end

            if (phase == 2 || phase == 11 || phase == 25)
                kind = 2;
            else
                kind = ($urandom_range(0, 99) < 70) ? 0 : 1;

            if (kind == 2)
            begin
                // Many distinct colors: fill the palette, hit old entries, then overflow.
                base   = ColorW'($urandom);
                stride = ColorW'($urandom) | 24'h000001;
                for (i = 0; i < MAX_COLORS; i++)
                    put_pixel(base + ColorW'(i) * stride, i == 0, 1'b0, NO_RES);
                put_pixel(base + ColorW'(MAX_COLORS - 1) * stride, 1'b0, 1'b0, NO_RES);
                put_pixel(base, 1'b0, 1'b0, NO_RES);
                put_pixel(base + ColorW'(MAX_COLORS + 7) * stride, 1'b0, 1'b0, NO_RES);
                for (i = 0; i < 6; i++)
                    put_pixel(ColorW'($urandom), 1'b0, 1'b0, NO_RES);
                put_pixel(base, 1'b0, 1'b0, NO_RES);
            end
            else if (kind == 0)
            begin
                // Few colors repeated, so most pixels hit an existing entry.
                pool_n = $urandom_range(1, 8);
                for (i = 0; i < pool_n; i++)
                begin
                    case ($urandom_range(0, 5))
                        0:       pool[i] = key_color;
                        1:       pool[i] = 24'hFFFFFF;
                        2:       pool[i] = 24'h000000;
                        default: pool[i] = ColorW'($urandom);
                    endcase
                end
                len = $urandom_range(8, 40);
                for (i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 99) < 85)
                        color = pool[$urandom_range(0, pool_n - 1)];
                    else
                        color = ColorW'($urandom);
                    first = (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0;
                    put_pixel(color, first, 1'b0, NO_RES);
                end
            end
            else
            begin
                // Noise: random colors with stray first-pixel marks.
                len = $urandom_range(10, 50);
                for (i = 0; i < len; i++)
                begin
                    first = (i == 0) ? ($urandom_range(0, 1) == 1) :
                                       ($urandom_range(0, 29) == 0);
                    put_pixel(ColorW'($urandom), first, 1'b0, NO_RES);
                end
            end
            phase++;
        end

        // Wait out every expected result, then watch for stray ones.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d pixels in %0d images over %0d phases, %0d register writes.",
                 pixels_sent, images_started, phase, reg_writes);
        $display("Checked %0d results: %0d new entries, %0d pixels under overflow.",
                 results_seen, new_entries, overflow_pixels);
        if (err_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[rgb_palette_builder.f]
sv/rpb_pkg.sv
sv/rpb_if.sv
sv/rpb_cell.sv
sv/rpb_ctrl.sv
sv/rgb_palette_builder.sv
sv/rpb_checker.sv
tb/sv/tb_rgb_palette_builder.sv
